>>> hdl/mfap_pkg.sv
// shared constants and types for the max flow core
`timescale 1ns / 1ps
package mfap_pkg;
  localparam int MAX_V   = 16;
  localparam int VID_W   = $clog2(MAX_V);
  localparam int CNT_W   = VID_W + 1;
  localparam int CAP_W   = 16;
  localparam int RES_W   = CAP_W + 1;
  localparam int FLOW_W  = 20;
  localparam int ADDR_W  = 2 * VID_W;
  localparam int DEPTH   = MAX_V * MAX_V;
  localparam logic [RES_W-1:0]  RES_MAX  = '1;
  localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

  typedef enum logic [1:0] {
    CFG_VCOUNT = 2'd0,
    CFG_SOURCE = 2'd1,
    CFG_SINK   = 2'd2
  } cfg_idx_t;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;
endpackage

>>> hdl/mfap_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module mfap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> hdl/max_flow_augmenting_path_core.sv
// max flow core: residual matrix, breadth-first search and path augmentation sequencer
// Usage:
//   in_*  : requests. in_tuser is the mode (0 load edge, 1 compute max flow).
//           a load writes capacity into matrix entry (from, to) when both are
//           below the effective vertex count; it gives no result.
//   out_* : one result per compute request, flow in out_tdata, bad flag in out_tuser.
//   cfg_* : register writes (0 vertex count, 1 source, 2 sink), always ready;
//           write only while the core is idle.
// Sequencing: loads can stream back to back.
//   a compute walks the matrix through one ram read port: each search reads every
//   column of each dequeued row, then a bottleneck walk and an update walk follow
//   the path edge by edge; a bad request goes straight to the result. in_tready is
//   low meanwhile.
// Reset: matrix reads as zero (per-entry valid flags cleared), registers go to
//   their defaults (16 vertices, source 0, sink 1); no clearing pass needed.
// Stall: a result waits in the output register; the core returns to idle and
//   takes loads, a finished compute holds until the output register is free.
`timescale 1ns / 1ps
module max_flow_augmenting_path_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // from_vertex[3:0], to_vertex[7:4], capacity[23:8]
  input  logic [0:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // total_flow[19:0], zero[23:20]
  output logic [0:0]  out_tuser,  // bad_request
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  localparam int VW = mfap_pkg::VID_W;
  localparam int CW = mfap_pkg::CNT_W;
  localparam int RW = mfap_pkg::RES_W;
  localparam int FW = mfap_pkg::FLOW_W;
  localparam int AW = mfap_pkg::ADDR_W;
  localparam int NV = mfap_pkg::MAX_V;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_BFS_INIT, S_BFS_POP, S_SCAN_RD, S_SCAN_CHK,
    S_MIN_RD, S_MIN_CHK, S_AUG_RD, S_AUG_FWD, S_AUG_REV, S_DONE
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   vcount_r;
  logic [VW-1:0]   src_r, dst_r;
  logic [NV-1:0]   visited_r;
  logic [VW-1:0]   parent_r [NV];
  logic [VW-1:0]   queue_r [NV];
  logic [CW-1:0]   head_r, tail_r, hops_r;
  logic [VW-1:0]   u_r, v_r;
  logic [RW-1:0]   bott_r;
  logic [FW-1:0]   flow_r;
  logic            bad_r;
  logic            out_valid_r, out_bad_r;
  logic [FW-1:0]   out_flow_r;
  logic [mfap_pkg::DEPTH-1:0] vld_r;
  logic            rvld_r;

  logic [CW-1:0]   n_eff;
  logic            in_acc, cfg_acc, load_ok, walk_end;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [RW-1:0]   ram_wdata, ram_rdata, rd_val;
  logic [RW:0]     rev_sum;
  logic [FW:0]     flow_sum;
  logic [VW-1:0]   in_from, in_to;
  logic [mfap_pkg::CAP_W-1:0] in_cap;

  assign n_eff    = (vcount_r > CW'(NV)) ? CW'(NV) : vcount_r;
  assign in_from  = in_tdata[VW-1:0];
  assign in_to    = in_tdata[2*VW-1:VW];
  assign in_cap   = in_tdata[2*VW+mfap_pkg::CAP_W-1:2*VW];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign load_ok  = (CW'(in_from) < n_eff) && (CW'(in_to) < n_eff);
  assign walk_end = (v_r == src_r) || (hops_r == CW'(NV));
  assign rd_val   = rvld_r ? ram_rdata : '0;
  assign rev_sum  = {1'b0, rd_val} + {1'b0, bott_r};
  assign flow_sum = {1'b0, flow_r} + (FW+1)'(bott_r);

  // one read and one write port drive all matrix traffic
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        ram_we    = in_acc && (in_tuser[0] == mfap_pkg::MODE_LOAD) && load_ok;
        ram_waddr = {in_from, in_to};
        ram_wdata = {1'b0, in_cap};
      end
      S_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {u_r, v_r};
      end
      S_MIN_RD, S_AUG_RD: begin
        ram_re    = !walk_end;
        ram_raddr = {parent_r[v_r], v_r};
      end
      S_AUG_FWD: begin
        ram_we    = 1'b1;
        ram_waddr = {u_r, v_r};
        ram_wdata = rd_val - bott_r;
        ram_re    = 1'b1;
        ram_raddr = {v_r, u_r};
      end
      S_AUG_REV: begin
        ram_we    = 1'b1;
        ram_waddr = {v_r, u_r};
        ram_wdata = rev_sum[RW] ? mfap_pkg::RES_MAX : rev_sum[RW-1:0];
      end
      default: begin
      end
    endcase
  end

  mfap_ram #(.WIDTH(RW), .DEPTH(mfap_pkg::DEPTH)) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= CW'(NV);
      src_r       <= '0;
      dst_r       <= VW'(1);
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      hops_r      <= '0;
      u_r         <= '0;
      v_r         <= '0;
      bott_r      <= mfap_pkg::RES_MAX;
      flow_r      <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_bad_r   <= 1'b0;
      out_flow_r  <= '0;
      vld_r       <= '0;
      rvld_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_acc) begin
        unique case (cfg_index)
          mfap_pkg::CFG_VCOUNT: vcount_r <= cfg_data;
          mfap_pkg::CFG_SOURCE: src_r    <= cfg_data[VW-1:0];
          mfap_pkg::CFG_SINK:   dst_r    <= cfg_data[VW-1:0];
          default: begin
          end
        endcase
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rvld_r <= vld_r[ram_raddr];
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser[0] == mfap_pkg::MODE_COMPUTE)) begin
            state_r <= S_START;
          end
        end
        S_START: begin
          flow_r <= '0;
          if ((CW'(src_r) >= n_eff) || (CW'(dst_r) >= n_eff) || (src_r == dst_r)) begin
            bad_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            bad_r   <= 1'b0;
            state_r <= S_BFS_INIT;
          end
        end
        S_BFS_INIT: begin
          visited_r     <= NV'(1) << src_r;
          head_r        <= '0;
          tail_r        <= CW'(1);
          queue_r[0]    <= src_r;
          state_r       <= S_BFS_POP;
        end
        S_BFS_POP: begin
          if ((head_r < tail_r) && (head_r < CW'(NV))) begin
            u_r     <= queue_r[head_r[VW-1:0]];
            head_r  <= head_r + CW'(1);
            v_r     <= '0;
            state_r <= S_SCAN_RD;
          end else if (visited_r[dst_r]) begin
            bott_r  <= mfap_pkg::RES_MAX;
            v_r     <= dst_r;
            hops_r  <= '0;
            state_r <= S_MIN_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!visited_r[v_r] && (rd_val != '0)) begin
            if (tail_r < CW'(NV)) begin
              queue_r[tail_r[VW-1:0]] <= v_r;
              tail_r <= tail_r + CW'(1);
            end
            parent_r[v_r]  <= u_r;
            visited_r[v_r] <= 1'b1;
          end
          v_r <= v_r + VW'(1);
          // last column of this row
          if (CW'(v_r) == n_eff - CW'(1)) begin
            state_r <= S_BFS_POP;
          end else begin
            state_r <= S_SCAN_RD;
          end
        end
        S_MIN_RD: begin
          if (walk_end) begin
            v_r     <= dst_r;
            hops_r  <= '0;
            state_r <= S_AUG_RD;
          end else begin
            u_r     <= parent_r[v_r];
            state_r <= S_MIN_CHK;
          end
        end
        S_MIN_CHK: begin
          if (rd_val < bott_r) begin
            bott_r <= rd_val;
          end
          v_r     <= u_r;
          hops_r  <= hops_r + CW'(1);
          state_r <= S_MIN_RD;
        end
        S_AUG_RD: begin
          if (walk_end) begin
            flow_r  <= flow_sum[FW] ? mfap_pkg::FLOW_MAX : flow_sum[FW-1:0];
            state_r <= S_BFS_INIT;
          end else begin
            u_r     <= parent_r[v_r];
            state_r <= S_AUG_FWD;
          end
        end
        S_AUG_FWD: begin
          state_r <= S_AUG_REV;
        end
        S_AUG_REV: begin
          v_r     <= u_r;
          hops_r  <= hops_r + CW'(1);
          state_r <= S_AUG_RD;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_bad_r   <= bad_r;
            out_flow_r  <= bad_r ? '0 : flow_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24-FW){1'b0}}, out_flow_r};
  assign out_tuser  = out_bad_r;

`ifndef NO_ASSERTIONS
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("bad request result carries nonzero flow");
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_IDLE) |-> (in_tvalid && in_tready && !in_tuser[0]))
    else $error("matrix written while idle without a load");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= tail_r) && (tail_r <= CW'(NV)))
    else $error("search queue pointers out of order");
  a_result_leaves_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_tready)) |=> (out_tvalid && state_r == S_IDLE))
    else $error("finished compute did not produce a result");
`endif
endmodule
